// ----- rtl/sentence_utf8_encoder_top_assert.svh -----
// Assertion macros shared by the checker of the sentence UTF-8 encoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SENTENCE_UTF8_ENCODER_TOP_ASSERT_SVH
`define SENTENCE_UTF8_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SUE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sentence encoder check failed");

// Next-cycle implication, checked out of reset.
`define SUE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sentence encoder check failed");

`endif

// ----- rtl/sue_pkg.sv -----
// Package of the sentence UTF-8 encoder: command type, character codes and limits.
// Depends on nothing; used by the front, queue, back and top modules of the block.
package sue_pkg;

    // Default depth of the command queue between front and back.
    localparam int DefaultQueueDepth = 2;

    // Configuration port.
    localparam int AddrWidth   = 3;
    localparam int DataWidth   = 32;
    localparam logic RegEnable = 1'b0;   // word index of the enable register

    // Input item kinds.
    localparam logic KindChar  = 1'b0;
    localparam logic KindFlush = 1'b1;

    // Characters with special handling.
    localparam logic [31:0] CharGt      = 32'h0000_003E;
    localparam logic [31:0] CharStar    = 32'h0000_002A;
    localparam logic [31:0] CharPeriod  = 32'h0000_002E;
    localparam logic [31:0] CharBang    = 32'h0000_0021;
    localparam logic [31:0] CharQuest   = 32'h0000_003F;
    localparam logic [31:0] CharNewline = 32'h0000_000A;

    // Upper bounds of the one, two, three and four byte encodings.
    localparam logic [31:0] LimitOne   = 32'h0000_0080;
    localparam logic [31:0] LimitTwo   = 32'h0000_0800;
    localparam logic [31:0] LimitThree = 32'h0001_0000;
    localparam logic [31:0] LimitFour  = 32'h0020_0000;

    // Lead and continuation byte marks.
    localparam logic [7:0] MarkCont  = 8'h80;
    localparam logic [7:0] MarkTwo   = 8'hC0;
    localparam logic [7:0] MarkThree = 8'hE0;
    localparam logic [7:0] MarkFour  = 8'hF0;

    // One unit of work for the back end: up to four bytes, or a bare end marker.
    typedef struct packed {
        logic [3:0][7:0] bytes;       // bytes[0] goes out first
        logic [1:0]      last_idx;    // number of results minus one
        logic            byte_valid;  // zero for a bare end marker
        logic            term;        // final result closes the sentence
    } cmd_t;

endpackage

// ----- rtl/sue_front.sv -----
// Front end of the sentence UTF-8 encoder: accepts items, encodes and tracks the sentence.
// Depends on sue_pkg.
module sue_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,     // [31:0] code_point
    input  logic              s_tuser,     // [0] kind
    input  logic              q_full,
    output logic              q_push,
    output sue_pkg::cmd_t     q_cmd
);

    logic          pending_reg;
    logic          pending_next;
    logic          accept;
    logic          is_term;
    logic          is_dropped;
    logic          enc_ok;
    sue_pkg::cmd_t enc_cmd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign is_term = (s_tdata == sue_pkg::CharPeriod) || (s_tdata == sue_pkg::CharBang)
                  || (s_tdata == sue_pkg::CharQuest)  || (s_tdata == sue_pkg::CharNewline);
    assign is_dropped = (s_tdata == sue_pkg::CharGt) || (s_tdata == sue_pkg::CharStar);

    // Split the code point into its UTF-8 bytes.
    always_comb begin
        enc_cmd            = '0;
        enc_cmd.byte_valid = 1'b1;
        enc_cmd.term       = is_term;
        enc_ok             = 1'b1;
        if (s_tdata < sue_pkg::LimitOne) begin
            enc_cmd.bytes[0] = s_tdata[7:0];
            enc_cmd.last_idx = 2'd0;
        end else if (s_tdata < sue_pkg::LimitTwo) begin
            enc_cmd.bytes[0] = sue_pkg::MarkTwo  | {3'b000, s_tdata[10:6]};
            enc_cmd.bytes[1] = sue_pkg::MarkCont | {2'b00, s_tdata[5:0]};
            enc_cmd.last_idx = 2'd1;
        end else if (s_tdata < sue_pkg::LimitThree) begin
            enc_cmd.bytes[0] = sue_pkg::MarkThree | {4'b0000, s_tdata[15:12]};
            enc_cmd.bytes[1] = sue_pkg::MarkCont  | {2'b00, s_tdata[11:6]};
            enc_cmd.bytes[2] = sue_pkg::MarkCont  | {2'b00, s_tdata[5:0]};
            enc_cmd.last_idx = 2'd2;
        end else if (s_tdata < sue_pkg::LimitFour) begin
            enc_cmd.bytes[0] = sue_pkg::MarkFour | {5'b00000, s_tdata[20:18]};
            enc_cmd.bytes[1] = sue_pkg::MarkCont | {2'b00, s_tdata[17:12]};
            enc_cmd.bytes[2] = sue_pkg::MarkCont | {2'b00, s_tdata[11:6]};
            enc_cmd.bytes[3] = sue_pkg::MarkCont | {2'b00, s_tdata[5:0]};
            enc_cmd.last_idx = 2'd3;
        end else begin
            // Too large to encode: no bytes, but the sentence still counts as open.
            enc_ok = 1'b0;
        end
    end

    // Classify the accepted item and decide what goes to the queue.
    always_comb begin
        pending_next = pending_reg;
        q_push       = 1'b0;
        q_cmd        = enc_cmd;
        if (accept) begin
            if (s_tuser == sue_pkg::KindFlush) begin
                pending_next = 1'b0;
                q_cmd        = '0;
                q_cmd.term   = 1'b1;
                q_push       = enable && pending_reg;
            end else if (enable && !is_dropped) begin
                pending_next = !is_term;
                q_push       = enc_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- rtl/sue_queue.sv -----
// Short command queue between the front and back ends of the sentence encoder.
// Depends on sue_pkg.
module sue_queue #(
    parameter int Depth = sue_pkg::DefaultQueueDepth   // at least 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sue_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sue_pkg::cmd_t head_cmd,
    output logic          not_empty,
    output logic          full
);

    localparam int PtrWidth = $clog2(Depth);
    localparam int CntWidth = $clog2(Depth + 1);
    localparam logic [PtrWidth-1:0] PtrMax = PtrWidth'(Depth - 1);
    localparam logic [CntWidth-1:0] CntMax = CntWidth'(Depth);

    sue_pkg::cmd_t        mem_reg [Depth];
    logic [PtrWidth-1:0]  wr_ptr_reg;
    logic [PtrWidth-1:0]  wr_ptr_next;
    logic [PtrWidth-1:0]  rd_ptr_reg;
    logic [PtrWidth-1:0]  rd_ptr_next;
    logic [CntWidth-1:0]  count_reg;
    logic [CntWidth-1:0]  count_next;

    assign head_cmd  = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CntMax);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrMax) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrMax) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/sue_back.sv -----
// Back end of the sentence encoder: sends the bytes of one command per result.
// Depends on sue_pkg.
module sue_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  sue_pkg::cmd_t head_cmd,
    input  logic          q_not_empty,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,     // [7:0] data_byte
    output logic [1:0]    m_tuser,     // [0] byte_valid, [1] last
    output logic          m_tlast      // sentence_end
);

    sue_pkg::cmd_t cur_cmd_reg;
    sue_pkg::cmd_t cur_cmd_next;
    logic          cur_valid_reg;
    logic          cur_valid_next;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    logic          at_last;

    assign at_last  = (idx_reg == cur_cmd_reg.last_idx);
    assign m_tvalid = cur_valid_reg;
    assign m_tdata  = cur_cmd_reg.bytes[idx_reg];
    assign m_tuser  = {at_last, cur_cmd_reg.byte_valid};
    assign m_tlast  = cur_cmd_reg.term && at_last;

    // A new command is taken when none is held or when the current one gives its final result.
    assign q_pop = q_not_empty && (!cur_valid_reg || (m_tready && at_last));

    always_comb begin
        cur_cmd_next   = cur_cmd_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop) begin
            cur_cmd_next   = head_cmd;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (cur_valid_reg && m_tready) begin
            if (at_last) begin
                cur_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_cmd_reg <= cur_cmd_next;
    end

endmodule

// ----- rtl/sentence_utf8_encoder_top.sv -----
// Top level of the sentence UTF-8 encoder: configuration register and channel wiring.
// Depends on sue_pkg, sue_front, sue_queue and sue_back.
//
// Channel   Direction  Payload                                   Accepted when
// s_        in         tdata code_point, tuser kind              s_tvalid && s_tready
// m_        out        tdata data_byte, tuser {last,byte_valid}, m_tvalid && m_tready
//                      tlast sentence_end
// apb       in         enable at byte address 0                  psel, penable, pwrite
//
// An encoded character gives one to four results on the output side, sent one at a time
// by the byte serializer in the back end; the front takes an input request in every
// cycle that the command queue has room.
// An encoded request goes through the queue and the back's command register to m_tvalid.
// Reset is synchronous and active low; it clears enable and the pending sentence.
// Output stalls fill the queue and then hold s_tready low; input gaps only idle the back.
module sentence_utf8_encoder_top #(
    parameter int QueueDepth = sue_pkg::DefaultQueueDepth
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input requests.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] code_point
    input  logic                          s_tuser,   // [0] kind
    // Result requests.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] data_byte
    output logic [1:0]                    m_tuser,   // [0] byte_valid, [1] last
    output logic                          m_tlast,   // sentence_end
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sue_pkg::AddrWidth-1:0] paddr,
    input  logic [sue_pkg::DataWidth-1:0] pwdata,
    output logic [sue_pkg::DataWidth-1:0] prdata,
    output logic                          pready
);

    logic          enable_reg;
    logic          enable_next;
    logic          cfg_hit;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_not_empty;
    sue_pkg::cmd_t q_in_cmd;
    sue_pkg::cmd_t q_head_cmd;

    // The register file is a single word; the low two address bits are ignored.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[sue_pkg::AddrWidth-1] == sue_pkg::RegEnable);
    assign prdata  = cfg_hit ? {{(sue_pkg::DataWidth-1){1'b0}}, enable_reg} : '0;

    always_comb begin
        enable_next = enable_reg;
        if (psel && penable && pwrite && pready && cfg_hit) begin
            enable_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else begin
            enable_reg <= enable_next;
        end
    end

    // The front classifies each request and keeps the sentence-pending flag.
    sue_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    // Commands wait here so that output stalls do not reach the input at once.
    sue_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in_cmd),
        .pop       (q_pop),
        .head_cmd  (q_head_cmd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // The back sends one byte, or one bare end marker, per cycle while m_tready is high.
    sue_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (q_head_cmd),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- rtl/sue_checker.sv -----
// Port-level checker of the sentence UTF-8 encoder, bound to the top level.
// Depends on sentence_utf8_encoder_top_assert.svh.
`include "sentence_utf8_encoder_top_assert.svh"

module sue_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result keeps its contents.
    `SUE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // A bare end marker carries a zero byte and closes both the sentence and the request.
    `SUE_ASSERT_NOW(a_marker_form, aclk, aresetn, m_tvalid && !m_tuser[0],
                    m_tdata == 8'h00 && m_tlast && m_tuser[1])

    // A sentence only ends on the final result of a request.
    `SUE_ASSERT_NOW(a_end_is_last, aclk, aresetn, m_tvalid && m_tlast, m_tuser[1])

    // Results before the final one are continuation or lead bytes of a multi-byte code.
    `SUE_ASSERT_NOW(a_mid_is_byte, aclk, aresetn, m_tvalid && !m_tuser[1],
                    m_tuser[0] && m_tdata[7] && !m_tlast)

endmodule

bind sentence_utf8_encoder_top sue_checker u_checker (.*);
